// File: rtl/gfpw_pkg.sv
// Shared types and constants of the gray framebuffer pixel writer.
package gfpw_pkg;

  typedef enum logic [1:0] {
    OP_STREAM  = 2'd0,
    OP_DRAW    = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [2:0] CFG_ROTATION     = 3'd0;
  localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_BYTE_SWAP    = 3'd3;
  localparam logic [2:0] CFG_WIN_LEFT     = 3'd4;
  localparam logic [2:0] CFG_WIN_RIGHT    = 3'd5;
  localparam logic [2:0] CFG_WIN_TOP      = 3'd6;
  localparam logic [2:0] CFG_WIN_BOTTOM   = 3'd7;

  localparam logic [9:0] PANEL_WIDTH_RST  = 10'd960;
  localparam logic [9:0] PANEL_HEIGHT_RST = 10'd540;

  // floor(s / 48) == (s * 1366) >> 16 for every s up to 748
  localparam logic [10:0] GRAY_RECIP = 11'd1366;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = 2;

  typedef struct packed {
    logic [1:0]  rotation;
    logic [9:0]  panel_width;
    logic [9:0]  panel_height;
    logic        byte_swap;
    logic [15:0] win_left;
    logic [15:0] win_right;
    logic [15:0] win_top;
    logic [15:0] win_bottom;
  } cfg_t;

  typedef enum logic [1:0] {
    K_NONE  = 2'd0,
    K_WRITE = 2'd1,
    K_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  gray;
    logic [17:0] addr;
  } q_entry_t;

endpackage

// File: rtl/gray4_framebuffer_pixel_writer_unit.sv
// Top level of the 4-bit gray packed framebuffer pixel writer.
//
// Items arrive on the in_ stream: tuser carries the operation (stream pixel,
// draw pixel, read byte, restart window), tlast marks the last streamed pixel
// of a chunk, tdata carries the RGB565 word, position, gray level and read
// address. Every accepted item gives exactly one transfer on the out_ stream:
// tdata is the read byte (zero unless a read), tuser says a pixel was stored.
// The user writes cfg_ port registers only while idle; the block won't check.
//
// Throughput is one item per cycle unless the receiver stalls; the byte
// read-modify-write of the store forwards the previous write, so adjacent
// pixels in one byte do not stall. An item passes the queue slot, the address
// stage (rotate, clip, row multiply), the store read and the output register.
//
// After reset the store is filled with white, one byte a cycle, over all
// FB_WIDTH*FB_HEIGHT/2 bytes (259200 at the defaults); in_tready stays low
// until then. When the receiver stalls the back end holds, the four-entry
// queue fills, and in_tready drops once the queue is full.
module gray4_framebuffer_pixel_writer_unit import gfpw_pkg::*; #(
  parameter int unsigned FB_WIDTH  = 960,
  parameter int unsigned FB_HEIGHT = 540
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pixel_rgb[15:0], pos_x[31:16], pos_y[47:32], gray_level[51:48],
  // byte_address[69:52], zero[71:70]
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  output logic [7:0]  out_tdata,
  // pixel_written[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     accept;
  logic     push;
  q_entry_t entry;
  logic     q_full;
  logic     pop;
  logic     head_valid;
  q_entry_t head;
  logic     busy;

  assign in_tready = !busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation     <= 2'd0;
      cfg_r.panel_width  <= PANEL_WIDTH_RST;
      cfg_r.panel_height <= PANEL_HEIGHT_RST;
      cfg_r.byte_swap    <= 1'b0;
      cfg_r.win_left     <= '0;
      cfg_r.win_right    <= '0;
      cfg_r.win_top      <= '0;
      cfg_r.win_bottom   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROTATION:     cfg_r.rotation     <= cfg_wdata[1:0];
        CFG_PANEL_WIDTH:  cfg_r.panel_width  <= cfg_wdata[9:0];
        CFG_PANEL_HEIGHT: cfg_r.panel_height <= cfg_wdata[9:0];
        CFG_BYTE_SWAP:    cfg_r.byte_swap    <= cfg_wdata[0];
        CFG_WIN_LEFT:     cfg_r.win_left     <= cfg_wdata;
        CFG_WIN_RIGHT:    cfg_r.win_right    <= cfg_wdata;
        CFG_WIN_TOP:      cfg_r.win_top      <= cfg_wdata;
        CFG_WIN_BOTTOM:   cfg_r.win_bottom   <= cfg_wdata;
      endcase
    end
  end

  gfpw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .accept        (accept),
    .op            (op_t'(in_tuser)),
    .pixel_rgb     (in_tdata[15:0]),
    .last_in_chunk (in_tlast),
    .pos_x         (in_tdata[31:16]),
    .pos_y         (in_tdata[47:32]),
    .gray_level    (in_tdata[51:48]),
    .byte_address  (in_tdata[69:52]),
    .push          (push),
    .entry         (entry)
  );

  gfpw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gfpw_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/gfpw_front.sv
// Front end: window cursor, gray conversion and item classification.
module gfpw_front import gfpw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  op_t         op,
  input  logic [15:0] pixel_rgb,
  input  logic        last_in_chunk,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  input  logic [3:0]  gray_level,
  input  logic [17:0] byte_address,
  output logic        push,
  output q_entry_t    entry
);

  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic [15:0] chunk_row_r, chunk_row_nxt;

  logic [16:0] col;
  logic [16:0] row;
  logic [16:0] col_inc;
  logic        taken;
  logic [15:0] word;
  logic [9:0]  gsum;
  logic [20:0] gprod;

  assign col     = {1'b0, cfg.win_left} + {1'b0, cur_col_r};
  assign row     = {1'b0, chunk_row_r} + {1'b0, cur_row_r};
  assign col_inc = col + 17'd1;
  assign taken   = (col < {1'b0, cfg.win_right}) && (row < {1'b0, cfg.win_bottom});

  assign word  = cfg.byte_swap ? {pixel_rgb[7:0], pixel_rgb[15:8]} : pixel_rgb;
  assign gsum  = {word[15:11], 3'b000} + {2'b00, word[10:5], 2'b00} + {word[4:0], 3'b000};
  assign gprod = 21'(gsum) * 21'(GRAY_RECIP);

  assign push = accept;

  always_comb begin
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    chunk_row_nxt = chunk_row_r;
    entry.kind    = K_NONE;
    entry.x       = pos_x;
    entry.y       = pos_y;
    entry.gray    = gray_level;
    entry.addr    = byte_address;
    unique case (op)
      OP_STREAM: begin
        entry.x    = col[15:0];
        entry.y    = row[15:0];
        entry.gray = gprod[19:16];
        if (taken) begin
          entry.kind = K_WRITE;
          if (col_inc >= {1'b0, cfg.win_right}) begin
            cur_col_nxt = '0;
            cur_row_nxt = cur_row_r + 16'd1;
          end else begin
            cur_col_nxt = cur_col_r + 16'd1;
          end
        end
        if (last_in_chunk) begin
          if (taken) begin
            chunk_row_nxt = row[15:0] + 16'd1;
          end
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
      end
      OP_DRAW: begin
        entry.kind = K_WRITE;
      end
      OP_READ: begin
        entry.kind = K_READ;
      end
      OP_RESTART: begin
        if ((cfg.win_left | cfg.win_right | cfg.win_top | cfg.win_bottom) != 16'd0) begin
          chunk_row_nxt = cfg.win_top;
        end
        cur_col_nxt = '0;
        cur_row_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      chunk_row_r <= '0;
    end else if (accept) begin
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      chunk_row_r <= chunk_row_nxt;
    end
  end

endmodule

// File: rtl/gfpw_queue.sv
// Short queue between front end and back end.
module gfpw_queue import gfpw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  q_entry_t        slots_r [QDEPTH];
  logic [QPW-1:0]  wr_ptr_r;
  logic [QPW-1:0]  rd_ptr_r;
  logic [QPW:0]    count_r;
  logic            do_push;
  logic            do_pop;

  assign full       = (count_r == (QPW+1)'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/gfpw_back.sv
// Back end: rotation, clipping, addressing and byte read-modify-write of the store.
module gfpw_back import gfpw_pkg::*; #(
  parameter int unsigned FB_WIDTH  = 960,
  parameter int unsigned FB_HEIGHT = 540
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  output logic     busy,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic [7:0] out_tdata,
  output logic [0:0] out_tuser
);

  localparam int unsigned STORE_BYTES = (FB_WIDTH * FB_HEIGHT) / 2;
  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned IW = 20;
  localparam int unsigned CW = (AW > IW) ? AW : IW;
  localparam logic [CW:0]   STORE_C   = (CW+1)'(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  logic [7:0] mem [STORE_BYTES];

  logic          advance;
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // address stage
  logic [15:0] w16, h16, xp, yp;
  logic        in_panel;
  logic        a_valid_r;
  kind_t       a_kind_r;
  logic        a_wr_r;
  logic [9:0]  a_xp_r;
  logic [19:0] a_prod_r;
  logic [3:0]  a_gray_r;
  logic [17:0] a_addr_r;

  // merge stage
  logic [IW-1:0] idx;
  logic          wr_ok;
  logic          rd_ok;
  logic [AW-1:0] maddr;
  logic          b_valid_r;
  logic          b_wr_r;
  logic          b_rd_r;
  logic          b_odd_r;
  logic [3:0]    b_gray_r;
  logic [AW-1:0] b_maddr_r;
  logic [7:0]    rd_data_r;
  logic          lw_valid_r;
  logic [AW-1:0] lw_addr_r;
  logic [7:0]    lw_data_r;
  logic [7:0]    merged;
  logic [7:0]    new_byte;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign advance = !out_tvalid || out_tready;
  assign pop     = advance && head_valid;
  assign busy    = clearing_r;

  assign w16 = {6'b0, cfg.panel_width};
  assign h16 = {6'b0, cfg.panel_height};

  always_comb begin
    unique case (cfg.rotation)
      2'd1: begin
        xp = w16 - head.y - 16'd1;
        yp = head.x;
      end
      2'd2: begin
        xp = w16 - head.x - 16'd1;
        yp = h16 - head.y - 16'd1;
      end
      2'd3: begin
        xp = head.y;
        yp = h16 - head.x - 16'd1;
      end
      default: begin
        xp = head.x;
        yp = head.y;
      end
    endcase
  end

  assign in_panel = (xp < w16) && (yp < h16);

  always_ff @(posedge clk) begin
    if (advance) begin
      a_kind_r <= head.kind;
      a_wr_r   <= (head.kind == K_WRITE) && in_panel;
      a_xp_r   <= xp[9:0];
      a_prod_r <= 20'(yp[9:0]) * 20'(cfg.panel_width);
      a_gray_r <= head.gray;
      a_addr_r <= head.addr;
    end
  end

  assign idx   = {1'b0, a_prod_r[19:1]} + {11'b0, a_xp_r[9:1]};
  assign wr_ok = a_wr_r && ((CW+1)'(idx) < STORE_C);
  assign rd_ok = (a_kind_r == K_READ) && ((CW+1)'(a_addr_r) < STORE_C);
  assign maddr = (a_kind_r == K_READ) ? AW'(CW'(a_addr_r)) : AW'(CW'(idx));

  assign merged   = (lw_valid_r && (lw_addr_r == b_maddr_r)) ? lw_data_r : rd_data_r;
  assign new_byte = b_odd_r ? {b_gray_r, merged[3:0]} : {merged[7:4], b_gray_r};

  always_ff @(posedge clk) begin
    if (advance) begin
      b_wr_r    <= wr_ok;
      b_rd_r    <= rd_ok;
      b_odd_r   <= a_xp_r[0];
      b_gray_r  <= a_gray_r;
      b_maddr_r <= maddr;
      rd_data_r <= mem[maddr];
      lw_addr_r <= b_maddr_r;
      lw_data_r <= new_byte;
    end
  end

  always_comb begin
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = 8'hFF;
    end else begin
      mem_we    = advance && b_valid_r && b_wr_r;
      mem_waddr = b_maddr_r;
      mem_wdata = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata <= b_rd_r ? merged : 8'h00;
      out_tuser <= b_wr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      a_valid_r  <= 1'b0;
      b_valid_r  <= 1'b0;
      lw_valid_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end
      end
      if (advance) begin
        a_valid_r  <= head_valid;
        b_valid_r  <= a_valid_r;
        lw_valid_r <= b_valid_r && b_wr_r;
        out_tvalid <= b_valid_r;
      end
    end
  end

endmodule

// File: test/gfpw_result_checker.sv
// Checker for the gray framebuffer pixel writer: tracks its state and compares each output transfer.
module gfpw_result_checker import gfpw_pkg::*; #(
  parameter int unsigned FB_WIDTH  = 960,
  parameter int unsigned FB_HEIGHT = 540
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // pixel_rgb[15:0], pos_x[31:16], pos_y[47:32], gray_level[51:48],
  // byte_address[69:52], zero[71:70]
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  // operation[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // read_data[7:0]
  input  logic [7:0]  out_tdata,
  // pixel_written[0]
  input  logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int unsigned fail_count,
  output int unsigned results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_BYTES = FB_WIDTH * FB_HEIGHT / 2;

  typedef struct packed {
    logic [7:0] read_data;
    logic       pixel_written;
  } pixel_result_t;

  pixel_result_t owed_results[$];
  logic [7:0]    frame_model [STORE_BYTES];
  cfg_t          regs;
  int unsigned   col_off;
  int unsigned   row_off;
  int unsigned   chunk_start;
  int unsigned   fail_tally = 0;

  function automatic logic [3:0] rgb565_gray(logic [15:0] w);
    int unsigned r, g, b;
    r = 32'(w[15:11]) << 3;
    g = 32'(w[10:5]) << 2;
    b = 32'(w[4:0]) << 3;
    return 4'(((r + g + b) / 3) >> 4);
  endfunction

  // rotate, clip and store one nibble; returns 1 when the nibble landed
  function automatic logic store_gray_at(logic [15:0] x, logic [15:0] y, logic [3:0] gray);
    logic [15:0] xp, yp, t;
    int unsigned byte_idx;
    xp = x;
    yp = y;
    case (regs.rotation)
      2'd1: begin
        t = xp;
        xp = yp;
        yp = t;
        xp = 16'(regs.panel_width) - xp - 16'd1;
      end
      2'd2: begin
        xp = 16'(regs.panel_width) - xp - 16'd1;
        yp = 16'(regs.panel_height) - yp - 16'd1;
      end
      2'd3: begin
        t = xp;
        xp = yp;
        yp = t;
        yp = 16'(regs.panel_height) - yp - 16'd1;
      end
      default: ;
    endcase
    if (xp >= regs.panel_width || yp >= regs.panel_height) return 1'b0;
    byte_idx = (32'(yp) * 32'(regs.panel_width)) / 2 + 32'(xp) / 2;
    if (byte_idx >= STORE_BYTES) return 1'b0;
    if (xp[0]) frame_model[byte_idx][7:4] = gray;
    else frame_model[byte_idx][3:0] = gray;
    return 1'b1;
  endfunction

  function automatic pixel_result_t apply_pixel_item(op_t op, logic [15:0] rgb, logic last,
                                                     logic [15:0] px, logic [15:0] py,
                                                     logic [3:0] gray, logic [17:0] addr);
    pixel_result_t res;
    int unsigned col, row;
    logic taken;
    logic [15:0] w;
    res = '0;
    case (op)
      OP_STREAM: begin
        col = regs.win_left + col_off;
        row = chunk_start + row_off;
        taken = (col < regs.win_right) && (row < regs.win_bottom);
        if (taken) begin
          w = regs.byte_swap ? {rgb[7:0], rgb[15:8]} : rgb;
          res.pixel_written = store_gray_at(col[15:0], row[15:0], rgb565_gray(w));
          col_off++;
          if (regs.win_left + col_off >= regs.win_right) begin
            col_off = 0;
            row_off++;
          end
        end
        if (last) begin
          if (taken) chunk_start = (row + 1) & 32'hFFFF;
          col_off = 0;
          row_off = 0;
        end
      end
      OP_DRAW: begin
        res.pixel_written = store_gray_at(px, py, gray);
      end
      OP_READ: begin
        if (addr < STORE_BYTES) res.read_data = frame_model[addr];
      end
      default: begin
        if (|{regs.win_left, regs.win_right, regs.win_top, regs.win_bottom})
          chunk_start = regs.win_top;
        col_off = 0;
        row_off = 0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_BYTES; i++) frame_model[i] = 8'hFF;
      owed_results.delete();
      col_off = 0;
      row_off = 0;
      chunk_start = 0;
      regs.rotation = '0;
      regs.panel_width = PANEL_WIDTH_RST;
      regs.panel_height = PANEL_HEIGHT_RST;
      regs.byte_swap = 1'b0;
      regs.win_left = '0;
      regs.win_right = '0;
      regs.win_top = '0;
      regs.win_bottom = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROTATION:     regs.rotation = cfg_wdata[1:0];
          CFG_PANEL_WIDTH:  regs.panel_width = cfg_wdata[9:0];
          CFG_PANEL_HEIGHT: regs.panel_height = cfg_wdata[9:0];
          CFG_BYTE_SWAP:    regs.byte_swap = cfg_wdata[0];
          CFG_WIN_LEFT:     regs.win_left = cfg_wdata;
          CFG_WIN_RIGHT:    regs.win_right = cfg_wdata;
          CFG_WIN_TOP:      regs.win_top = cfg_wdata;
          CFG_WIN_BOTTOM:   regs.win_bottom = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected out transfer: read_data %02h, pixel_written %0b",
                 out_tdata, out_tuser[0]);
          fail_tally++;
        end else begin
          want = owed_results.pop_front();
          if (out_tdata !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, out_tdata);
            fail_tally++;
          end
          if (out_tuser[0] !== want.pixel_written) begin
            $error("pixel_written: expected %0b, got %0b", want.pixel_written, out_tuser[0]);
            fail_tally++;
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_results.push_back(apply_pixel_item(op_t'(in_tuser), in_tdata[15:0], in_tlast,
                                                in_tdata[31:16], in_tdata[47:32],
                                                in_tdata[51:48], in_tdata[69:52]));
    end
    fail_count <= fail_tally;
    results_owed <= owed_results.size();
  end

endmodule

// File: test/tb_gray4_framebuffer_pixel_writer_unit.sv
// Testbench top for the gray framebuffer pixel writer: stimulus, pacing and verdict.
module tb_gray4_framebuffer_pixel_writer_unit import gfpw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FBW          = 960;
  localparam int unsigned FBH          = 540;
  localparam int unsigned STORE_BYTES  = FBW * FBH / 2;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  typedef enum int unsigned {
    PACE_FULL,
    PACE_SLOW_SOURCE,
    PACE_SLOW_SINK,
    PACE_BOTH
  } pace_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned cycle_count;
  pace_t       pace;
  cfg_t        cur;

  gray4_framebuffer_pixel_writer_unit #(
    .FB_WIDTH (FBW),
    .FB_HEIGHT(FBH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gfpw_result_checker #(
    .FB_WIDTH (FBW),
    .FB_HEIGHT(FBH)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_owed(results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[gray4_framebuffer_pixel_writer_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    case (pace)
      PACE_SLOW_SINK: out_tready <= $urandom_range(99) >= 78;
      PACE_BOTH:      out_tready <= $urandom_range(99) >= 26;
      default:        out_tready <= 1'b1;
    endcase
  end

  function automatic cfg_t mk_cfg(logic [1:0] rot, logic [9:0] w, logic [9:0] h, logic swap,
                                  logic [15:0] l, logic [15:0] r, logic [15:0] t,
                                  logic [15:0] b);
    cfg_t c;
    c.rotation = rot;
    c.panel_width = w;
    c.panel_height = h;
    c.byte_swap = swap;
    c.win_left = l;
    c.win_right = r;
    c.win_top = t;
    c.win_bottom = b;
    return c;
  endfunction

  function automatic cfg_t with_window(cfg_t c);
    int unsigned span;
    span = (c.panel_width > c.panel_height) ? c.panel_width : c.panel_height;
    c.win_left = 16'($urandom_range(0, span));
    c.win_right = c.win_left + 16'($urandom_range(0, 6));
    c.win_top = 16'($urandom_range(0, span));
    c.win_bottom = c.win_top + 16'($urandom_range(0, 4));
    return c;
  endfunction

  function automatic logic [17:0] pick_addr();
    int unsigned span;
    if ($urandom_range(99) < 15) return 18'($urandom);
    span = (32'(cur.panel_width) * 32'(cur.panel_height)) / 2 + 3;
    if (span > 32'h3FFFF) span = 32'h3FFFF;
    return 18'($urandom_range(0, span));
  endfunction

  function automatic logic [15:0] pick_pos();
    int unsigned lim;
    if ($urandom_range(99) < 15) return 16'($urandom);
    lim = (cur.panel_width > cur.panel_height) ? cur.panel_width : cur.panel_height;
    return 16'($urandom_range(0, lim + 4) - 2);
  endfunction

  task automatic send_item(op_t op, logic [15:0] rgb, logic last, logic [15:0] px,
                           logic [15:0] py, logic [3:0] gray, logic [17:0] addr);
    int unsigned idle_pct;
    idle_pct = (pace == PACE_SLOW_SOURCE) ? 78 : (pace == PACE_BOTH) ? 26 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tlast <= last;
    in_tdata <= {2'b00, addr, gray, py, px, rgb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic stream_px(logic [15:0] rgb, logic last);
    send_item(OP_STREAM, rgb, last, 16'($urandom), 16'($urandom), 4'($urandom), 18'($urandom));
  endtask

  task automatic draw_px(logic [15:0] x, logic [15:0] y, logic [3:0] gray);
    send_item(OP_DRAW, 16'($urandom), 1'($urandom), x, y, gray, 18'($urandom));
  endtask

  task automatic read_byte(logic [17:0] addr);
    send_item(OP_READ, 16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom), addr);
  endtask

  task automatic restart_window();
    send_item(OP_RESTART, 16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
              4'($urandom), 18'($urandom));
  endtask

  // hold until every transfer owed has come out, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    logic [15:0] vals [8];
    vals[CFG_ROTATION] = 16'(c.rotation);
    vals[CFG_PANEL_WIDTH] = 16'(c.panel_width);
    vals[CFG_PANEL_HEIGHT] = 16'(c.panel_height);
    vals[CFG_BYTE_SWAP] = 16'(c.byte_swap);
    vals[CFG_WIN_LEFT] = c.win_left;
    vals[CFG_WIN_RIGHT] = c.win_right;
    vals[CFG_WIN_TOP] = c.win_top;
    vals[CFG_WIN_BOTTOM] = c.win_bottom;
    cur = c;
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed chunks inside the window, with reads, draws and noise between
  task automatic random_traffic(int unsigned n);
    int unsigned issued, run_len, cols, reads;
    issued = 0;
    while (issued < n) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(1) == 1) begin
          restart_window();
          issued++;
        end
        cols = (cur.win_right > cur.win_left) ? cur.win_right - cur.win_left : 1;
        if (cols > 12) cols = 12;
        run_len = $urandom_range(1, cols * 3 + 2);
        for (int k = 1; k <= run_len; k++) stream_px(16'($urandom), k == run_len);
        issued += run_len;
        reads = $urandom_range(0, 2);
        repeat (reads) read_byte(pick_addr());
        issued += reads;
        if ($urandom_range(3) == 0) begin
          draw_px(pick_pos(), pick_pos(), 4'($urandom));
          issued++;
        end
      end else begin
        send_item(op_t'($urandom_range(3)), 16'($urandom), 1'($urandom), pick_pos(),
                  pick_pos(), 4'($urandom), pick_addr());
        issued++;
      end
    end
  endtask

  task automatic run_phase(cfg_t c, pace_t p, int unsigned n);
    settle();
    pace <= p;
    set_config(c);
    random_traffic(n);
  endtask

  initial begin
    cfg_t c;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    in_tuser <= OP_STREAM;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROTATION;
    cfg_wdata <= '0;
    pace <= PACE_FULL;
    cur = mk_cfg(2'd0, PANEL_WIDTH_RST, PANEL_HEIGHT_RST, 1'b0, '0, '0, '0, '0);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // hold through the white fill after reset
    while (!in_tready) @(posedge clk);

    // reset settings: white store, empty window, clipping at every edge
    read_byte(18'd0);
    read_byte(18'(STORE_BYTES - 1));
    read_byte(18'(STORE_BYTES));
    read_byte(18'h3FFFF);
    stream_px(16'hFFFF, 1'b1);
    restart_window();
    draw_px(16'd0, 16'd0, 4'h0);
    draw_px(16'd1, 16'd0, 4'h5);
    draw_px(16'd959, 16'd539, 4'hA);
    draw_px(16'hFFFF, 16'd0, 4'h3);
    draw_px(16'd960, 16'd0, 4'h3);
    draw_px(16'd0, 16'd540, 4'h3);
    draw_px(16'h7FFF, 16'h8000, 4'h3);
    read_byte(18'd0);
    read_byte(18'(STORE_BYTES - 1));

    // window over the bottom-right corner, swapped words, chunk overrun
    settle();
    set_config(mk_cfg(2'd0, 10'd960, 10'd540, 1'b1, 16'd958, 16'd962, 16'd538, 16'd541));
    restart_window();
    stream_px(16'h00F8, 1'b0);
    stream_px(16'hFFFF, 1'b0);
    stream_px(16'h0000, 1'b0);
    stream_px(16'h1F00, 1'b1);
    stream_px(16'hE007, 1'b0);
    stream_px(16'h1234, 1'b1);
    read_byte(18'(STORE_BYTES - 1));
    read_byte(18'(STORE_BYTES - 2));
    read_byte(18'(STORE_BYTES - 481));

    run_phase(with_window(mk_cfg(2'd0, 10'd16, 10'd8, 1'b0, '0, '0, '0, '0)), PACE_FULL, 150);
    run_phase(with_window(mk_cfg(2'd1, 10'd12, 10'd10, 1'b1, '0, '0, '0, '0)),
              PACE_SLOW_SOURCE, 130);
    run_phase(with_window(mk_cfg(2'd2, 10'd9, 10'd7, 1'b0, '0, '0, '0, '0)),
              PACE_SLOW_SINK, 130);
    run_phase(with_window(mk_cfg(2'd3, 10'd10, 10'd13, 1'b1, '0, '0, '0, '0)), PACE_BOTH, 130);
    run_phase(with_window(mk_cfg(2'd1, 10'd960, 10'd540, 1'b0, '0, '0, '0, '0)), PACE_BOTH, 100);
    run_phase(mk_cfg(2'd0, 10'd1, 10'd1, 1'b1, 16'd0, 16'd2, 16'd0, 16'd2), PACE_FULL, 80);
    run_phase(mk_cfg(2'd0, 10'd1023, 10'd1023, 1'b0, 16'd1000, 16'd1006, 16'd1015, 16'd1020),
              PACE_SLOW_SINK, 80);
    run_phase(mk_cfg(2'd3, 10'd0, 10'd5, 1'b0, 16'd0, 16'd3, 16'd0, 16'd3), PACE_FULL, 40);
    run_phase(mk_cfg(2'd0, 10'd20, 10'd20, 1'b0, 16'd0, 16'hFFFF, 16'hFFF8, 16'hFFFF),
              PACE_SLOW_SOURCE, 50);
    run_phase(mk_cfg(2'd2, 10'd20, 10'd20, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF),
              PACE_BOTH, 30);
    for (int i = 0; i < 4; i++) begin
      c = mk_cfg(2'($urandom), 10'($urandom_range(1, 24)), 10'($urandom_range(1, 24)),
                 1'($urandom), '0, '0, '0, '0);
      run_phase(with_window(c), pace_t'(i), 85);
    end

    settle();
    if (fail_count == 0) begin
      $display("[gray4_framebuffer_pixel_writer_unit] OK");
    end else begin
      $display("[gray4_framebuffer_pixel_writer_unit] ERROR");
    end
    $finish;
  end

endmodule
